// File: rtl/modular_power_product_core_macros.svh
// Assertion helpers used by mpp_ctrl
`ifndef MODULAR_POWER_PRODUCT_CORE_MACROS_SVH
`define MODULAR_POWER_PRODUCT_CORE_MACROS_SVH

// Check that an antecedent implies a consequent on the same edge
`define MPP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent on the next edge
`define MPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mpp_pkg.sv
package mpp_pkg;

    localparam int unsigned REG_IDX_BITS = 2;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_GROUP_MOD = 2'd0,
        REG_EXP_MOD   = 2'd1,
        REG_GEN       = 2'd2,
        REG_SPARE     = 2'd3
    } t_reg_idx;

    // Datapath operations: r = f(op) over a serial unit
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,      // load operands from input request
        OP_RED_EXP,   // reduce exponent modulo exponent modulus
        OP_RED_BASE,  // reduce base modulo group modulus
        OP_MUL_ACC,   // acc = acc * base
        OP_MUL_SQR,   // base = base * base
        OP_MUL_PROD,  // prod = prod * acc
        OP_CLR_PROD   // prod = 1
    } t_op;

    typedef struct packed {
        t_op  op;
        logic start;
    } t_cmd;

    typedef struct packed {
        logic done;       // serial unit finished
        logic exp_bit;    // current exponent bit
        logic last;       // held last flag
    } t_sts;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_EXP,
        ST_RED_BASE,
        ST_BIT,
        ST_ACC,
        ST_SQR,
        ST_PROD,
        ST_OUT
    } t_state;

endpackage

// File: rtl/mpp_datapath.sv
module mpp_datapath
    import mpp_pkg::*;
#(
    parameter int unsigned WORD_BITS = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic                 i_bit_shift,
    input  logic [WORD_BITS-1:0] i_group_modulus,
    input  logic [WORD_BITS-1:0] i_exponent_modulus,
    input  logic [WORD_BITS-1:0] i_generator,
    input  logic [WORD_BITS-1:0] i_base_value,
    input  logic                 i_use_generator,
    input  logic [WORD_BITS-1:0] i_exponent_value,
    input  logic                 i_last_term,
    output t_sts                 o_sts,
    output logic [WORD_BITS-1:0] o_product
);

    localparam int unsigned CNT_BITS = $clog2(WORD_BITS + 1);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

    logic [WORD_BITS-1:0] r_base, r_exp, r_acc, r_prod;
    logic                 r_last;
    // Serial unit: r_x scanned MSB first, r_y added, r_r accumulates
    logic [WORD_BITS-1:0] r_x, r_y, r_r;
    logic [WORD_BITS-1:0] r_m;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_busy, r_done;
    t_op                  r_op;

    logic                 m_small;
    logic [WORD_BITS:0]   dbl, dbl_red, sum, sum_red;
    logic [WORD_BITS-1:0] step_r;
    logic                 cur_bit;

    // Doubling / conditional add step, one bit per cycle
    always_comb begin
        m_small = (r_m < WORD_BITS'(2));
        dbl     = {r_r, 1'b0};
        dbl_red = (dbl >= {1'b0, r_m}) ? dbl - {1'b0, r_m} : dbl;
        cur_bit = r_x[WORD_BITS-1];
        sum     = dbl_red + {1'b0, r_y};
        sum_red = (sum >= {1'b0, r_m}) ? sum - {1'b0, r_m} : sum;
        step_r  = cur_bit ? sum_red[WORD_BITS-1:0] : dbl_red[WORD_BITS-1:0];
    end

    // Run serial unit and latch results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_prod <= WORD_BITS'(1);
        end else begin
            if (i_bit_shift) r_exp <= r_exp >> 1;
            if (i_cmd.start) begin
                r_op <= i_cmd.op;
                unique case (i_cmd.op)
                    OP_LOAD: begin
                        r_base <= i_use_generator ? i_generator : i_base_value;
                        r_exp  <= i_exponent_value;
                        r_last <= i_last_term;
                        r_acc  <= WORD_BITS'(1);
                        r_done <= 1'b1;
                    end
                    OP_CLR_PROD: begin
                        r_prod <= WORD_BITS'(1);
                        r_done <= 1'b1;
                    end
                    OP_NONE: r_done <= 1'b1;
                    default: begin
                        // Reductions compute x % m as x*1 mod m; (m<2 gives 0)
                        r_busy <= 1'b1;
                        r_done <= 1'b0;
                        r_cnt  <= '0;
                        r_r    <= '0;
                        priority case (i_cmd.op)
                            OP_RED_EXP: begin
                                r_m <= i_exponent_modulus;
                                r_x <= r_exp; r_y <= WORD_BITS'(1);
                            end
                            OP_RED_BASE: begin
                                r_m <= i_group_modulus;
                                r_x <= r_base; r_y <= WORD_BITS'(1);
                            end
                            OP_MUL_ACC: begin
                                r_m <= i_group_modulus;
                                r_x <= r_base; r_y <= r_acc;
                            end
                            OP_MUL_SQR: begin
                                r_m <= i_group_modulus;
                                r_x <= r_base; r_y <= r_base;
                            end
                            default: begin
                                r_m <= i_group_modulus;
                                r_x <= r_prod; r_y <= r_acc;
                            end
                        endcase
                    end
                endcase
            end else if (r_busy) begin
                r_r <= step_r;
                r_x <= r_x << 1;
                r_cnt <= r_cnt + CNT_BITS'(1);
                r_done <= (r_cnt == CNT_LAST);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    priority case (r_op)
                        OP_RED_EXP:  r_exp  <= m_small ? '0 : step_r;
                        OP_RED_BASE: r_base <= m_small ? '0 : step_r;
                        OP_MUL_ACC:  r_acc  <= m_small ? '0 : step_r;
                        OP_MUL_SQR:  r_base <= m_small ? '0 : step_r;
                        default:     r_prod <= m_small ? '0 : step_r;
                    endcase
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_sts = '{done: r_done, exp_bit: r_exp[0], last: r_last};
    assign o_product = r_prod;

endmodule

// File: rtl/mpp_ctrl.sv
module mpp_ctrl
    import mpp_pkg::*;
#(
    parameter int unsigned WORD_BITS = 63
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_bit_shift,
    output logic o_capture
);

    `include "modular_power_product_core_macros.svh"

    localparam int unsigned BIT_BITS = $clog2(WORD_BITS + 1);
    localparam logic [BIT_BITS-1:0] BIT_LAST = BIT_BITS'(WORD_BITS - 1);

    t_state              r_state, n_state;
    logic [BIT_BITS-1:0] r_bit, n_bit;
    logic                r_started, n_started;
    logic                r_out_valid, n_out_valid;

    // Next state
    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        n_started   = 1'b0;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_RED_EXP;
            ST_RED_EXP: begin
                n_started = 1'b1;
                if (r_started && i_sts.done) begin
                    n_state = ST_RED_BASE; n_started = 1'b0;
                end
            end
            ST_RED_BASE: begin
                n_started = 1'b1;
                if (r_started && i_sts.done) begin
                    n_state = ST_BIT; n_started = 1'b0; n_bit = '0;
                end
            end
            ST_BIT: n_state = i_sts.exp_bit ? ST_ACC : ST_SQR;
            ST_ACC: begin
                n_started = 1'b1;
                if (r_started && i_sts.done) begin
                    n_state = ST_SQR; n_started = 1'b0;
                end
            end
            ST_SQR: begin
                n_started = 1'b1;
                if (r_started && i_sts.done) begin
                    n_started = 1'b0;
                    n_bit = r_bit + BIT_BITS'(1);
                    n_state = (r_bit == BIT_LAST) ? ST_PROD : ST_BIT;
                end
            end
            ST_PROD: begin
                n_started = 1'b1;
                if (r_started && i_sts.done) begin
                    n_started = 1'b0;
                    n_state = i_sts.last ? ST_OUT : ST_IDLE;
                end
            end
            // Hold until the output register is free or being emptied
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd       = '{op: OP_NONE, start: 1'b0};
        o_in_ready  = 1'b0;
        o_bit_shift = 1'b0;
        o_capture   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = '{op: OP_LOAD, start: 1'b1};
            end
            ST_RED_EXP:  if (!r_started) o_cmd = '{op: OP_RED_EXP, start: 1'b1};
            ST_RED_BASE: if (!r_started) o_cmd = '{op: OP_RED_BASE, start: 1'b1};
            ST_ACC:      if (!r_started) o_cmd = '{op: OP_MUL_ACC, start: 1'b1};
            ST_SQR: begin
                if (!r_started) o_cmd = '{op: OP_MUL_SQR, start: 1'b1};
                o_bit_shift = r_started && i_sts.done;
            end
            ST_PROD:     if (!r_started) o_cmd = '{op: OP_MUL_PROD, start: 1'b1};
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_capture = 1'b1;
                    o_cmd = '{op: OP_CLR_PROD, start: 1'b1};
                end
            end
            default: ;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bit       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `MPP_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == ST_IDLE,
        "input ready outside idle")
    `MPP_ASSERT_NEXT(a_out_after_capture, i_clk, i_rst_n, o_capture, r_out_valid,
        "capture did not raise output valid")
    `MPP_ASSERT_IMP(a_capture_free, i_clk, i_rst_n, o_capture, !r_out_valid || i_out_ready,
        "result overwritten while pending")

endmodule

// File: rtl/modular_power_product_core.sv
// Channel | Signals                                       | Direction
// input   | i_in_valid/o_in_ready, base, gen, exp, last   | in
// output  | o_out_valid/i_out_ready, o_product_value      | out
// config  | i_cfg_we, i_cfg_index, i_cfg_data             | in
// Each request reduces its exponent and base, then scans the 63 exponent bits,
// multiplying the accumulator by the base on set bits and squaring the base;
// every modular multiply or reduction runs in a shared shift-add unit.
// Reset is synchronous and restores control state, configuration registers and a running product of 1.
// A result waits in the output register; a later result stalls the core, and
// so new requests, until the waiting one is taken.
module modular_power_product_core
    import mpp_pkg::*;
#(
    parameter int unsigned WORD_BITS = 63
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [WORD_BITS-1:0]    i_base_value,
    input  logic                    i_use_generator,
    input  logic [WORD_BITS-1:0]    i_exponent_value,
    input  logic                    i_last_term,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [WORD_BITS-1:0]    o_product_value,
    input  logic                    i_cfg_we,
    input  logic [REG_IDX_BITS-1:0] i_cfg_index,
    input  logic [WORD_BITS-1:0]    i_cfg_data
);

    logic [WORD_BITS-1:0] r_group_modulus, r_exponent_modulus, r_generator;
    logic [WORD_BITS-1:0] r_out, prod;
    t_cmd cmd;
    t_sts sts;
    logic bit_shift, capture;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_modulus    <= WORD_BITS'(64'd540431955285196831);
            r_exponent_modulus <= WORD_BITS'(64'd18014398509506561);
            r_generator        <= WORD_BITS'(64'd1073741824);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_GROUP_MOD: r_group_modulus    <= i_cfg_data;
                REG_EXP_MOD:   r_exponent_modulus <= i_cfg_data;
                REG_GEN:       r_generator        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture result before product clears
    always_ff @(posedge i_clk) begin
        if (capture) r_out <= prod;
    end

    mpp_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_sts(sts), .o_cmd(cmd), .o_bit_shift(bit_shift), .o_capture(capture)
    );

    mpp_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_bit_shift(bit_shift),
        .i_group_modulus(r_group_modulus), .i_exponent_modulus(r_exponent_modulus),
        .i_generator(r_generator), .i_base_value, .i_use_generator,
        .i_exponent_value, .i_last_term, .o_sts(sts), .o_product(prod)
    );

    assign o_product_value = r_out;

endmodule
